// ===== sv/iie_pkg.sv =====
// Shared types and constants for the integer instruction execute block.
package iie_pkg;

	localparam int MEM_WORDS = 1024;
	localparam int MEM_AW = $clog2(MEM_WORDS);
	localparam int REG_COUNT = 32;
	localparam int REG_AW = $clog2(REG_COUNT);
	localparam int LUI_SHIFT = 12;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_ADDI = 4'd1,
		OP_SUB  = 4'd2,
		OP_LUI  = 4'd3,
		OP_AND  = 4'd4,
		OP_OR   = 4'd5,
		OP_XOR  = 4'd6,
		OP_ANDI = 4'd7,
		OP_ORI  = 4'd8,
		OP_XORI = 4'd9,
		OP_SRLI = 4'd10,
		OP_SLLI = 4'd11,
		OP_SRL  = 4'd12,
		OP_SLL  = 4'd13,
		OP_SW   = 4'd14,
		OP_LW   = 4'd15
	} kind_t;

	typedef struct packed {
		logic              reg_we;
		logic [31:0]       value;
		logic              is_load;
		logic              mem_we;
		logic [MEM_AW-1:0] mem_idx;
		logic [9:0]        mem_address;
		logic              fault;
	} ex_t;

endpackage

// ===== sv/iie_regfile.sv =====
// Register file: 32 words, two registered read ports, one write port, valid bits for reset.
module iie_regfile (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [iie_pkg::REG_AW-1:0] ra1,
	input  logic [iie_pkg::REG_AW-1:0] ra2,
	output logic [31:0]               rdata1,
	output logic [31:0]               rdata2,
	input  logic                      we,
	input  logic [iie_pkg::REG_AW-1:0] wa,
	input  logic [31:0]               wd
);
	import iie_pkg::*;

	logic [31:0]          mem [REG_COUNT];
	logic [REG_COUNT-1:0] valid_q;
	logic [31:0]          d1_q;
	logic [31:0]          d2_q;
	logic                 v1_q;
	logic                 v2_q;

	// An entry that was never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
		end else begin
			if (we) begin
				valid_q[wa] <= 1'b1;
			end
			if (rd_en) begin
				v1_q <= valid_q[ra1];
				v2_q <= valid_q[ra2];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			d1_q <= mem[ra1];
			d2_q <= mem[ra2];
		end
	end

	assign rdata1 = v1_q ? d1_q : '0;
	assign rdata2 = v2_q ? d2_q : '0;

endmodule

// ===== sv/iie_dmem.sv =====
// Data memory with a single access port and a zeroing sweep after reset.
module iie_dmem (
	input  logic                      clk,
	input  logic                      arst_n,
	output logic                      clearing,
	input  logic                      re,
	input  logic                      we,
	input  logic [iie_pkg::MEM_AW-1:0] addr,
	input  logic [31:0]               wdata,
	output logic [31:0]               rdata
);
	import iie_pkg::*;

	logic [31:0]       mem [MEM_WORDS];
	logic [31:0]       rdata_q;
	logic              clearing_q;
	logic [MEM_AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + MEM_AW'(1);
			if (clr_addr_q == MEM_AW'(MEM_WORDS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// The read returns the old word, and port order follows program order.
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign clearing = clearing_q;
	assign rdata    = rdata_q;

endmodule

// ===== sv/iie_alu.sv =====
// Execute logic: operation select, address generation and range check.
module iie_alu (
	input  logic [3:0]                 kind,
	input  logic [iie_pkg::REG_AW-1:0] dest_reg,
	input  logic [19:0]                immediate,
	input  logic [31:0]                a,
	input  logic [31:0]                b,
	output iie_pkg::ex_t               ex
);
	import iie_pkg::*;

	logic [31:0] imm_ext;
	logic [31:0] addr;
	logic [31:0] value;
	logic        writes_reg;
	logic        addr_bad;
	logic        is_mem;

	assign imm_ext  = {{12{immediate[19]}}, immediate};
	assign addr     = b + imm_ext;
	assign addr_bad = addr >= 32'(MEM_WORDS);

	always_comb begin
		value      = '0;
		writes_reg = 1'b1;
		is_mem     = 1'b0;
		ex.is_load = 1'b0;
		ex.mem_we  = 1'b0;
		case (kind_t'(kind))
			OP_ADD:  value = a + b;
			OP_ADDI: value = a + imm_ext;
			OP_SUB:  value = a - b;
			OP_LUI:  value = imm_ext << LUI_SHIFT;
			OP_AND:  value = a & b;
			OP_OR:   value = a | b;
			OP_XOR:  value = a ^ b;
			OP_ANDI: value = a & imm_ext;
			OP_ORI:  value = a | imm_ext;
			OP_XORI: value = a ^ imm_ext;
			OP_SRLI: value = a >> immediate[4:0];
			OP_SLLI: value = a << immediate[4:0];
			OP_SRL:  value = a >> b[4:0];
			OP_SLL:  value = a << b[4:0];
			OP_SW: begin
				writes_reg = 1'b0;
				is_mem     = 1'b1;
				ex.mem_we  = !addr_bad;
			end
			OP_LW: begin
				writes_reg = !addr_bad;
				is_mem     = 1'b1;
				ex.is_load = !addr_bad;
			end
			default: begin
				writes_reg = 1'b0;
			end
		endcase
		// A store carries its data on the value field toward the memory port.
		ex.reg_we      = writes_reg && (dest_reg != '0);
		ex.value       = (ex.reg_we && !is_mem) ? value : (ex.mem_we ? a : '0);
		ex.mem_idx     = addr[MEM_AW-1:0];
		ex.mem_address = is_mem ? addr[9:0] : '0;
		ex.fault       = is_mem && addr_bad;
	end

endmodule

// ===== sv/integer_instruction_execute.sv =====
// Top level of the integer instruction execute block.
// Executes one decoded integer instruction per transfer on the input channel
// (kind, dest_reg, src1_reg, src2_reg, immediate) against a 32-word register
// file and a word-indexed data memory, and returns one result per instruction
// on the output channel (reg_written, written_reg, written_value, mem_written,
// mem_address, fault). Both channels use valid/ready.
// A result passes register read, execute with data memory access, then the
// output register. One instruction is accepted per cycle while in_ready is
// high; results of earlier instructions are forwarded, so dependent
// instructions may follow back to back.
// After reset the data memory is zeroed by a sweep over all MEM_WORDS words
// (1024), during which in_ready stays low. The register file reads zero
// after reset without a sweep.
// When the receiver stalls, the result waits in the output register and the
// earlier stages keep accepting until they are full.
module integer_instruction_execute (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         kind,
	input  logic [4:0]         dest_reg,
	input  logic [4:0]         src1_reg,
	input  logic [4:0]         src2_reg,
	input  logic signed [19:0] immediate,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               reg_written,
	output logic [4:0]         written_reg,
	output logic signed [31:0] written_value,
	output logic               mem_written,
	output logic [9:0]         mem_address,
	output logic               fault
);
	import iie_pkg::*;

	logic accept;
	logic en1;
	logic en2;
	logic en3;
	logic clearing;

	// Stage 1: decoded fields, register file read in flight.
	logic        v_s1;
	logic [3:0]  kind_s1;
	logic [4:0]  rd_s1;
	logic [4:0]  rs1_s1;
	logic [4:0]  rs2_s1;
	logic [19:0] imm_s1;

	// Stage 2: executed, load data in flight.
	logic        v_s2;
	logic        we_s2;
	logic [4:0]  rd_s2;
	logic [31:0] value_s2;
	logic        load_s2;
	logic        memw_s2;
	logic [9:0]  addr_s2;
	logic        fault_s2;
	logic [31:0] result_s2;

	// Stage 3: output register.
	logic        v_s3;
	logic        we_s3;
	logic [4:0]  rd_s3;
	logic [31:0] value_s3;
	logic        memw_s3;
	logic [9:0]  addr_s3;
	logic        fault_s3;

	logic [31:0] rf_a;
	logic [31:0] rf_b;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [31:0] mem_rdata;
	logic        rf_we;
	ex_t         ex;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1 && !clearing;
	assign accept   = in_valid && in_ready;

	iie_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.ra1    (src1_reg),
		.ra2    (src2_reg),
		.rdata1 (rf_a),
		.rdata2 (rf_b),
		.we     (rf_we),
		.wa     (rd_s2),
		.wd     (result_s2)
	);

	// Older results missed by the register read in stage 1 sit in stage 2 or 3.
	always_comb begin
		if (v_s2 && we_s2 && rd_s2 == rs1_s1) begin
			op_a = result_s2;
		end else if (v_s3 && we_s3 && rd_s3 == rs1_s1) begin
			op_a = value_s3;
		end else begin
			op_a = rf_a;
		end
		if (v_s2 && we_s2 && rd_s2 == rs2_s1) begin
			op_b = result_s2;
		end else if (v_s3 && we_s3 && rd_s3 == rs2_s1) begin
			op_b = value_s3;
		end else begin
			op_b = rf_b;
		end
	end

	iie_alu u_alu (
		.kind      (kind_s1),
		.dest_reg  (rd_s1),
		.immediate (imm_s1),
		.a         (op_a),
		.b         (op_b),
		.ex        (ex)
	);

	iie_dmem u_dmem (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.re       (v_s1 && en2 && ex.is_load),
		.we       (v_s1 && en2 && ex.mem_we),
		.addr     (ex.mem_idx),
		.wdata    (ex.value),
		.rdata    (mem_rdata)
	);

	assign result_s2 = load_s2 ? mem_rdata : value_s2;
	assign rf_we     = v_s2 && en3 && we_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= accept;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			rd_s1   <= dest_reg;
			rs1_s1  <= src1_reg;
			rs2_s1  <= src2_reg;
			imm_s1  <= immediate;
		end
		if (en2 && v_s1) begin
			we_s2    <= ex.reg_we;
			rd_s2    <= ex.reg_we ? rd_s1 : '0;
			value_s2 <= ex.mem_we ? '0 : ex.value;
			load_s2  <= ex.is_load && ex.reg_we;
			memw_s2  <= ex.mem_we;
			addr_s2  <= ex.mem_address;
			fault_s2 <= ex.fault;
		end
		if (en3 && v_s2) begin
			we_s3    <= we_s2;
			rd_s3    <= rd_s2;
			value_s3 <= we_s2 ? result_s2 : '0;
			memw_s3  <= memw_s2;
			addr_s3  <= addr_s2;
			fault_s3 <= fault_s2;
		end
	end

	assign out_valid     = v_s3;
	assign reg_written   = we_s3;
	assign written_reg   = rd_s3;
	assign written_value = signed'(value_s3);
	assign mem_written   = memw_s3;
	assign mem_address   = addr_s3;
	assign fault         = fault_s3;

endmodule
